// ===== src/greedy_interval_selector_defines.svh =====
// assertion macros used by greedy_interval_selector
`ifndef GREEDY_INTERVAL_SELECTOR_DEFINES_SVH
`define GREEDY_INTERVAL_SELECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GIS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define GIS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GIS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define GIS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== src/gis_pkg.sv =====
package gis_pkg;

    localparam int MAX_ACTIVITIES_DEF = 64;
    localparam int TIME_BITS_DEF      = 32;
    localparam int ID_BITS_DEF        = 16;

    localparam logic [1:0] KEY_END   = 2'd0;
    localparam logic [1:0] KEY_DUR   = 2'd1;
    localparam logic [1:0] KEY_START = 2'd2;

    localparam logic [2:0] MODE_HOLD  = 3'd0;
    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_EVEN  = 3'd2;
    localparam logic [2:0] MODE_ODD   = 3'd3;
    localparam logic [2:0] MODE_SHIFT = 3'd4;

    typedef struct packed {
        logic [15:0] activity_id;
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic        last_activity;
    } t_item;

    typedef struct packed {
        logic [15:0] chosen_id;
        logic [6:0]  chosen_total;
        logic        overflow_flag;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] sort_key;
    } t_cell_ctrl;

endpackage

// ===== src/gis_cell.sv =====
module gis_cell #(
    parameter int IDX       = 0,
    parameter int ID_BITS   = gis_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = gis_pkg::TIME_BITS_DEF,
    parameter int CNT_W     = 7
) (
    input  logic                 i_clk,
    input  gis_pkg::t_cell_ctrl  i_ctrl,
    input  logic [CNT_W-1:0]     i_count,
    input  logic [ID_BITS-1:0]   i_ld_id,
    input  logic [TIME_BITS-1:0] i_ld_start,
    input  logic [TIME_BITS-1:0] i_ld_end,
    input  logic [ID_BITS-1:0]   i_lo_id,
    input  logic [TIME_BITS-1:0] i_lo_start,
    input  logic [TIME_BITS-1:0] i_lo_end,
    input  logic [ID_BITS-1:0]   i_hi_id,
    input  logic [TIME_BITS-1:0] i_hi_start,
    input  logic [TIME_BITS-1:0] i_hi_end,
    output logic [ID_BITS-1:0]   o_id,
    output logic [TIME_BITS-1:0] o_start,
    output logic [TIME_BITS-1:0] o_end
);

    localparam logic [CNT_W-1:0] IDX_SELF = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(IDX + 1);
    localparam bit IS_ODD = (IDX % 2) == 1;
    localparam bit HAS_LO = IDX > 0;

    logic [ID_BITS-1:0]   r_id,    n_id;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [TIME_BITS-1:0] r_end,   n_end;
    logic [TIME_BITS-1:0] w_key_own, w_key_lo, w_key_hi;
    logic                 w_am_low;
    logic                 w_take_hi, w_take_lo;

    function automatic logic [TIME_BITS-1:0] f_key(input logic [1:0] key,
                                                   input logic [TIME_BITS-1:0] s,
                                                   input logic [TIME_BITS-1:0] e);
        unique case (key)
            gis_pkg::KEY_DUR:   f_key = (e >= s) ? (e - s) : '0;
            gis_pkg::KEY_START: f_key = s;
            default:            f_key = e;
        endcase
    endfunction

    assign w_key_own = f_key(i_ctrl.sort_key, r_start, r_end);
    assign w_key_lo  = f_key(i_ctrl.sort_key, i_lo_start, i_lo_end);
    assign w_key_hi  = f_key(i_ctrl.sort_key, i_hi_start, i_hi_end);

    // pairing: even phase joins (2k, 2k+1), odd phase joins (2k+1, 2k+2)
    assign w_am_low  = (i_ctrl.mode == gis_pkg::MODE_EVEN) ? !IS_ODD : IS_ODD;
    assign w_take_hi = w_am_low && (IDX_NEXT < i_count) && (w_key_own > w_key_hi);
    assign w_take_lo = !w_am_low && HAS_LO && (IDX_SELF < i_count) && (w_key_lo > w_key_own);

    always_comb begin
        n_id    = r_id;
        n_start = r_start;
        n_end   = r_end;
        unique case (i_ctrl.mode)
            gis_pkg::MODE_LOAD: begin
                if (i_count == IDX_SELF) begin
                    n_id    = i_ld_id;
                    n_start = i_ld_start;
                    n_end   = i_ld_end;
                end
            end
            gis_pkg::MODE_EVEN, gis_pkg::MODE_ODD: begin
                if (w_take_hi) begin
                    n_id    = i_hi_id;
                    n_start = i_hi_start;
                    n_end   = i_hi_end;
                end else if (w_take_lo) begin
                    n_id    = i_lo_id;
                    n_start = i_lo_start;
                    n_end   = i_lo_end;
                end
            end
            gis_pkg::MODE_SHIFT: begin
                n_id    = i_hi_id;
                n_start = i_hi_start;
                n_end   = i_hi_end;
            end
            default: begin
                n_id    = r_id;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_start <= n_start;
        r_end   <= n_end;
    end

    assign o_id    = r_id;
    assign o_start = r_start;
    assign o_end   = r_end;

endmodule

// ===== src/greedy_interval_selector.sv =====
// Activities load one per cycle while busy is low; each that fits is written into the next
// cell of a row of MAX_ACTIVITIES cells, and the rest are dropped. The item marked last
// starts the run: the stored activities sort themselves in the cell row by odd-even
// neighbor exchange, then shift toward cell 0 while the head is tested against the end of
// the last chosen activity, and a done state emits the final result. busy stays high until
// the run closes. Results come one per strobe cycle, at most one per cycle, and must be taken when shown.
`include "greedy_interval_selector_defines.svh"

module greedy_interval_selector #(
    parameter int MAX_ACTIVITIES = gis_pkg::MAX_ACTIVITIES_DEF,
    parameter int TIME_BITS      = gis_pkg::TIME_BITS_DEF,
    parameter int ID_BITS        = gis_pkg::ID_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  gis_pkg::t_item   i_item,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    output logic             o_strobe,
    output gis_pkg::t_result o_result
);

    localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ACTIVITIES);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           r_state;
    logic [1:0]           r_sort_key;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_step;
    logic [CNT_W-1:0]     r_total;
    logic                 r_drop;
    logic                 r_any;
    logic [TIME_BITS-1:0] r_last_end;
    logic [ID_BITS-1:0]   r_pend_id;
    logic                 r_strobe;
    gis_pkg::t_result     r_result;

    gis_pkg::t_cell_ctrl  w_ctrl;
    logic                 w_accept;
    logic                 w_room;
    logic                 w_pick;
    logic [CNT_W-1:0]     w_last_step;

    logic [ID_BITS-1:0]   w_id    [MAX_ACTIVITIES];
    logic [TIME_BITS-1:0] w_start [MAX_ACTIVITIES];
    logic [TIME_BITS-1:0] w_end   [MAX_ACTIVITIES];

    assign busy        = (r_state != ST_LOAD);
    assign w_accept    = start && !busy;
    assign w_room      = (r_count != MAX_CNT);
    assign w_last_step = CNT_W'(r_count - 1'b1);
    assign w_pick      = !r_any || (w_start[0] >= r_last_end);

    always_comb begin
        w_ctrl.sort_key = r_sort_key;
        unique case (r_state)
            ST_LOAD: w_ctrl.mode = (w_accept && w_room) ? gis_pkg::MODE_LOAD
                                                        : gis_pkg::MODE_HOLD;
            ST_SORT: w_ctrl.mode = r_step[0] ? gis_pkg::MODE_ODD : gis_pkg::MODE_EVEN;
            ST_SCAN: w_ctrl.mode = gis_pkg::MODE_SHIFT;
            default: w_ctrl.mode = gis_pkg::MODE_HOLD;
        endcase
    end

    for (genvar g = 0; g < MAX_ACTIVITIES; g++) begin : g_cell
        logic [ID_BITS-1:0]   w_lo_id,    w_hi_id;
        logic [TIME_BITS-1:0] w_lo_start, w_hi_start;
        logic [TIME_BITS-1:0] w_lo_end,   w_hi_end;

        if (g == 0) begin : g_lo_edge
            assign w_lo_id    = '0;
            assign w_lo_start = '0;
            assign w_lo_end   = '0;
        end else begin : g_lo_link
            assign w_lo_id    = w_id[g-1];
            assign w_lo_start = w_start[g-1];
            assign w_lo_end   = w_end[g-1];
        end

        if (g == MAX_ACTIVITIES - 1) begin : g_hi_edge
            assign w_hi_id    = '0;
            assign w_hi_start = '0;
            assign w_hi_end   = '0;
        end else begin : g_hi_link
            assign w_hi_id    = w_id[g+1];
            assign w_hi_start = w_start[g+1];
            assign w_hi_end   = w_end[g+1];
        end

        gis_cell #(
            .IDX       (g),
            .ID_BITS   (ID_BITS),
            .TIME_BITS (TIME_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_count    (r_count),
            .i_ld_id    (ID_BITS'(i_item.activity_id)),
            .i_ld_start (TIME_BITS'(i_item.start_time)),
            .i_ld_end   (TIME_BITS'(i_item.end_time)),
            .i_lo_id    (w_lo_id),
            .i_lo_start (w_lo_start),
            .i_lo_end   (w_lo_end),
            .i_hi_id    (w_hi_id),
            .i_hi_start (w_hi_start),
            .i_hi_end   (w_hi_end),
            .o_id       (w_id[g]),
            .o_start    (w_start[g]),
            .o_end      (w_end[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key <= gis_pkg::KEY_END;
        end else if (i_cfg_we) begin
            r_sort_key <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_step     <= '0;
            r_total    <= '0;
            r_drop     <= 1'b0;
            r_any      <= 1'b0;
            r_last_end <= '0;
            r_strobe   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    r_strobe <= 1'b0;
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= CNT_W'(r_count + 1'b1);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_item.last_activity) begin
                            r_state <= ST_SORT;
                            r_step  <= '0;
                        end
                    end
                end
                ST_SORT: begin
                    r_strobe <= 1'b0;
                    if (r_step == w_last_step) begin
                        r_state <= ST_SCAN;
                        r_step  <= '0;
                        r_total <= '0;
                        r_any   <= 1'b0;
                    end else begin
                        r_step <= CNT_W'(r_step + 1'b1);
                    end
                end
                ST_SCAN: begin
                    r_strobe <= w_pick && r_any;
                    if (w_pick) begin
                        r_any      <= 1'b1;
                        r_last_end <= w_start[0] >= r_last_end || !r_any ? w_end[0]
                                                                         : r_last_end;
                        r_total    <= CNT_W'(r_total + 1'b1);
                    end
                    r_step <= CNT_W'(r_step + 1'b1);
                    if (r_step == w_last_step) begin
                        r_state <= ST_DONE;
                    end
                end
                default: begin
                    r_strobe   <= 1'b1;
                    r_state    <= ST_LOAD;
                    r_count    <= '0;
                    r_drop     <= 1'b0;
                    r_any      <= 1'b0;
                    r_last_end <= '0;
                end
            endcase
        end
    end

    // pending chosen item is held back one pick so the final one can carry the count
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && w_pick) begin
            r_pend_id              <= w_id[0];
            r_result.chosen_id     <= 16'(r_pend_id);
            r_result.chosen_total  <= '0;
            r_result.overflow_flag <= r_drop;
            r_result.last_result   <= 1'b0;
        end else if (r_state == ST_DONE) begin
            r_result.chosen_id     <= 16'(r_pend_id);
            r_result.chosen_total  <= 7'(r_total);
            r_result.overflow_flag <= r_drop;
            r_result.last_result   <= 1'b1;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `GIS_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= MAX_CNT, "count past capacity")
    `GIS_ASSERT_NEXT(a_done_last, i_clk, i_rst_n, r_state == ST_DONE, o_strobe && o_result.last_result, "final item missing")
    `GIS_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == ST_DONE, !busy && r_count == '0, "run did not close")
    `GIS_ASSERT_NEXT(a_load_quiet, i_clk, i_rst_n, r_state == ST_LOAD, !o_strobe, "item out while loading")

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import gis_pkg::*;

    localparam int         CAP         = MAX_ACTIVITIES_DEF;
    localparam logic [1:0] KEY_SPARE   = 2'd3;
    localparam int         ITEM_TARGET = 360;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       is_cfg;
        logic [1:0] key_val;
        t_item      it;
        logic       typed;
        t_result    want;
    } t_step;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    logic       busy;
    t_item      i_item     = '0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_data = '0;
    logic       o_strobe;
    t_result    o_result;

    always #5 i_clk = ~i_clk;

    greedy_interval_selector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // model of the activity set and the ordering key
    logic [15:0] held_id    [CAP];
    logic [31:0] held_start [CAP];
    logic [31:0] held_end   [CAP];
    int          held_count = 0;
    bit          lost_items = 1'b0;
    logic [1:0]  order_key  = KEY_END;
    t_result     chosen_q[$];
    t_result     due;
    int          mismatches = 0;
    int          cycles     = 0;
    int          sent       = 0;
    bit          calm       = 1'b0;

    function automatic logic [31:0] rank_of(int slot);
        case (order_key)
            KEY_DUR: begin
                return (held_end[slot] >= held_start[slot]) ?
                       held_end[slot] - held_start[slot] : '0;
            end
            KEY_START: return held_start[slot];
            default:   return held_end[slot];
        endcase
    endfunction

    function automatic void select_activities(t_item it);
        int          order [CAP];
        int          n;
        int          i;
        int          j;
        int          cur;
        int          total;
        logic [31:0] fence;
        t_result     r;
        if (held_count < CAP) begin
            held_id[held_count]    = it.activity_id;
            held_start[held_count] = it.start_time;
            held_end[held_count]   = it.end_time;
            held_count++;
        end else begin
            lost_items = 1'b1;
        end
        if (!it.last_activity) return;
        n = held_count;
        for (i = 0; i < n; i++) order[i] = i;
        // stable insertion sort, ties keep arrival order
        for (i = 1; i < n; i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && rank_of(order[j - 1]) > rank_of(cur)) begin
                order[j] = order[j - 1];
                j--;
            end
            order[j] = cur;
        end
        total = 0;
        fence = '0;
        for (i = 0; i < n; i++) begin
            if (total == 0 || held_start[order[i]] >= fence) begin
                r = '0;
                r.chosen_id     = held_id[order[i]];
                r.overflow_flag = lost_items;
                chosen_q.push_back(r);
                total++;
                fence = held_end[order[i]];
            end
        end
        r = chosen_q.pop_back();
        r.chosen_total = total[6:0];
        r.last_result  = 1'b1;
        chosen_q.push_back(r);
        held_count = 0;
        lost_items = 1'b0;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (chosen_q.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_result.chosen_id), '0);
            end else begin
                due = chosen_q.pop_front();
                if (o_result.chosen_id !== due.chosen_id)
                    report_mismatch("chosen_id", 32'(o_result.chosen_id),
                                    32'(due.chosen_id));
                if (o_result.chosen_total !== due.chosen_total)
                    report_mismatch("chosen_total", 32'(o_result.chosen_total),
                                    32'(due.chosen_total));
                if (o_result.overflow_flag !== due.overflow_flag)
                    report_mismatch("overflow_flag", 32'(o_result.overflow_flag),
                                    32'(due.overflow_flag));
                if (o_result.last_result !== due.last_result)
                    report_mismatch("last_result", 32'(o_result.last_result),
                                    32'(due.last_result));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic t_step row_item(logic [15:0] id, logic [31:0] s, logic [31:0] e,
                                       logic last);
        t_step r;
        r = '0;
        r.it.activity_id   = id;
        r.it.start_time    = s;
        r.it.end_time      = e;
        r.it.last_activity = last;
        return r;
    endfunction

    function automatic t_step row_key(logic [1:0] k);
        t_step r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.key_val = k;
        return r;
    endfunction

    // one-activity set: that activity is the whole selection
    function automatic t_step row_single(logic [15:0] id, logic [31:0] s, logic [31:0] e);
        t_step r;
        r = row_item(id, s, e, 1'b1);
        r.typed             = 1'b1;
        r.want.chosen_id    = id;
        r.want.chosen_total = 7'd1;
        r.want.last_result  = 1'b1;
        return r;
    endfunction

    task automatic drive_item(t_step st);
        int n0;
        while (!calm && $urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= st.it;
        do @(posedge i_clk); while (busy);
        n0 = chosen_q.size();
        select_activities(st.it);
        if (st.typed) begin
            while (chosen_q.size() > n0) void'(chosen_q.pop_back());
            chosen_q.push_back(st.want);
        end
        sent++;
    endtask

    task automatic write_key(logic [1:0] k);
        start <= 1'b0;
        do @(posedge i_clk); while (chosen_q.size() != 0 || busy);
        repeat (3) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= k;
        @(posedge i_clk);
        order_key = k;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_step       plan[$];
        int          base;
        int          set_size;
        int          k;
        logic [31:0] s;
        logic [31:0] e;

        plan.push_back(row_single(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF));
        plan.push_back(row_single(16'h0000, 32'hFFFF_FFFF, 32'h0000_0000));
        plan.push_back(row_item(16'd1, 32'd0, 32'd10, 1'b0));
        plan.push_back(row_item(16'd2, 32'd5, 32'd8, 1'b0));
        plan.push_back(row_item(16'd3, 32'd8, 32'd12, 1'b0));
        plan.push_back(row_item(16'd4, 32'd12, 32'd12, 1'b1));
        // duration key with a reversed interval
        plan.push_back(row_key(KEY_DUR));
        plan.push_back(row_item(16'd5, 32'd100, 32'd50, 1'b0));
        plan.push_back(row_item(16'd6, 32'd0, 32'd30, 1'b0));
        plan.push_back(row_item(16'd7, 32'd40, 32'd45, 1'b0));
        plan.push_back(row_item(16'd8, 32'd45, 32'd46, 1'b1));
        plan.push_back(row_key(KEY_START));
        plan.push_back(row_item(16'd9, 32'd20, 32'd30, 1'b0));
        plan.push_back(row_item(16'd10, 32'd0, 32'd25, 1'b0));
        plan.push_back(row_item(16'd11, 32'd5, 32'd5, 1'b0));
        plan.push_back(row_item(16'd12, 32'd5, 32'd5, 1'b0));
        plan.push_back(row_item(16'd13, 32'd25, 32'd40, 1'b1));
        // unused key value falls back to end time
        plan.push_back(row_key(KEY_SPARE));
        plan.push_back(row_item(16'd14, 32'd0, 32'd10, 1'b0));
        plan.push_back(row_item(16'd15, 32'd10, 32'd20, 1'b0));
        plan.push_back(row_item(16'd16, 32'd3, 32'd9, 1'b1));
        // key changed in the middle of a set
        plan.push_back(row_key(KEY_END));
        plan.push_back(row_item(16'd17, 32'd0, 32'd100, 1'b0));
        plan.push_back(row_key(KEY_START));
        plan.push_back(row_item(16'd18, 32'd50, 32'd60, 1'b1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[p]) begin
            if (plan[p].is_cfg) write_key(plan[p].key_val);
            else drive_item(plan[p]);
        end

        base = sent;
        while (sent - base < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) set_size = $urandom_range(CAP - 4, CAP + 6);
            else set_size = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) write_key(2'($urandom_range(0, 3)));
            for (k = 0; k < set_size; k++) begin
                calm = (sent - base >= 150) && (sent - base < 230);
                if (k > 0 && $urandom_range(0, 49) == 0) write_key(2'($urandom_range(0, 3)));
                case ($urandom_range(0, 9))
                    0: begin
                        s = $urandom;
                        e = $urandom;
                    end
                    1: begin
                        s = $urandom_range(0, 300);
                        e = s - $urandom_range(1, 40);
                    end
                    default: begin
                        s = $urandom_range(0, 300);
                        e = s + $urandom_range(0, 60);
                    end
                endcase
                drive_item(row_item(16'($urandom_range(0, 65535)), s, e,
                                    k == set_size - 1));
            end
        end

        start <= 1'b0;
        do @(posedge i_clk); while (chosen_q.size() != 0 || busy);
        repeat (2 * CAP + 2) @(posedge i_clk);
        if (mismatches == 0 && chosen_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== greedy_interval_selector.f =====
+incdir+src
src/gis_pkg.sv
src/gis_cell.sv
src/greedy_interval_selector.sv
verif/testbench.sv
